### hdl/sobel_edge_gradient_magnitude_unit_macros.svh
// assertion macros for the sobel edge gradient unit
// expects signals clk and rst_n in the scope of use
`ifndef SOBEL_EDGE_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_EDGE_GRADIENT_MAGNITUDE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SEGM_ASSERT_IMP(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("segm: same-cycle check failed");
`define SEGM_ASSERT_NXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("segm: next-cycle check failed");
`else
`define SEGM_ASSERT_IMP(lbl, pre, con)
`define SEGM_ASSERT_NXT(lbl, pre, con)
`endif
`endif

### hdl/segm_pkg.sv
// shared constants of the sobel edge gradient unit
// no dependencies
package segm_pkg;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd1024;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
endpackage

### hdl/segm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module segm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### hdl/sobel_edge_gradient_magnitude_unit.sv
// sobel 3x3 edge detector on a raster pixel stream
// depends on segm_pkg, segm_ram and the macros header
//
// usage: pixels enter on in_valid/in_stall, one word each, in raster order.
// a word is taken when in_valid is high and in_stall low. frame size is set
// over the apb port (register 0 width at 0x0, register 1 height at 0x4);
// any write restarts the frame. results leave on out_valid/out_stall in
// raster order, trailing the input by one row and one column; the last row
// and column are flushed with the final pixels of the frame.
// sequence: a pixel reads both line stores at its column in the accept cycle,
// the read data comes back in the next cycle (S_READ) and is written back with
// the new pixel. each result then passes a gradient state (S_CALC), a squaring
// state (S_SQ) and the steps of a bit-serial square root (S_ROOT) before it
// is shown in S_OUT; a pixel without results goes back to idle after S_READ,
// and no new pixel is taken until every result of the last one has left.
// a stalled result holds its word and keeps in_stall high.
// reset: counters, window and registers clear synchronously (width and height to
// 1024); line stores need no clearing as unwritten entries never feed a result.
`include "sobel_edge_gradient_magnitude_unit_macros.svh"
module sobel_edge_gradient_magnitude_unit #(
  parameter int MAX_WIDTH = segm_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [segm_pkg::PIX_W-1:0]         in_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [7:0]                  out_grad_x,
  output logic signed [7:0]                  out_grad_y,
  output logic [7:0]                         out_magnitude,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > segm_pkg::FW_W) ? WW : segm_pkg::FW_W;
  localparam int FH_W  = segm_pkg::FH_W;
  localparam int PW    = segm_pkg::PIX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  typedef struct packed {
    logic row_one;
    logic last_row;
    logic col_one;
    logic col_last;
    logic emit;
  } pix_flags_t;

  logic [2:0] state_r, state_nxt;
  logic [segm_pkg::FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [CW-1:0] col_r;
  logic [FH_W-1:0] row_r;
  logic [PW-1:0] pix_r;
  pix_flags_t flags_r;
  logic [PW-1:0] win_r [9];
  logic [1:0] emi_r;
  logic [2:0] k_r;
  logic signed [11:0] gx_r, gy_r;
  logic [14:0] sx_r;
  logic [15:0] sres_r;
  logic signed [7:0] gxo_r, gyo_r;
  logic re_r, fe_r;

  // effective frame size
  logic [CMP_W-1:0] fw_ext, w_eff;
  logic [CW-1:0] w_last;
  logic [FH_W-1:0] h_eff, h_last;
  always_comb begin
    fw_ext = CMP_W'(fw_r);
    priority if (fw_ext < CMP_W'(2)) begin
      w_eff = CMP_W'(2);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_last = CW'(w_eff - CMP_W'(1));
    h_eff  = (fh_r < FH_W'(2)) ? FH_W'(2) : fh_r;
    h_last = h_eff - FH_W'(1);
  end

  logic in_acc, cfg_wr;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == segm_pkg::REG_HEIGHT) ? 32'(fh_r) : 32'(fw_r);

  // line stores
  logic [PW-1:0] up_rd, lo_rd;
  logic st_we;
  assign st_we = (state_r == S_READ);

  segm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(st_we), .waddr(col_r), .wdata(lo_rd),
    .re(in_acc), .raddr(col_r), .rdata(up_rd)
  );
  segm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
    .clk(clk), .we(st_we), .waddr(col_r), .wdata(pix_r),
    .re(in_acc), .raddr(col_r), .rdata(lo_rd)
  );

  // results of this word: main window, right edge, and their folded copies
  logic is_edge, fold, emi_last;
  assign is_edge  = flags_r.col_last && emi_r[0];
  assign fold     = flags_r.col_last ? emi_r[1] : emi_r[0];
  assign emi_last = flags_r.col_last ? (flags_r.last_row ? (emi_r == 2'd3) : (emi_r == 2'd1))
                                     : (flags_r.last_row ? (emi_r == 2'd1) : (emi_r == 2'd0));

  logic [1:0] lc, mc, rc;
  logic signed [11:0] px [3][3];
  logic signed [11:0] gx_c, gy_c;
  always_comb begin
    lc = is_edge ? 2'd1 : (flags_r.col_one ? 2'd2 : 2'd0);
    mc = is_edge ? 2'd2 : 2'd1;
    rc = is_edge ? 2'd1 : 2'd2;
    for (int k = 0; k < 3; k++) begin
      int src;
      src = fold ? ((k == 1) ? 2 : 1) : k;
      px[0][k] = $signed({4'b0, win_r[3 * lc + src]});
      px[1][k] = $signed({4'b0, win_r[3 * mc + src]});
      px[2][k] = $signed({4'b0, win_r[3 * rc + src]});
    end
    gx_c = (px[2][0] - px[0][0]) + 12'sd2 * (px[2][1] - px[0][1]) + (px[2][2] - px[0][2]);
    gy_c = (px[0][2] + 12'sd2 * px[1][2] + px[2][2])
         - (px[0][0] + 12'sd2 * px[1][0] + px[2][0]);
  end

  function automatic logic signed [7:0] div8_even(input logic signed [11:0] g);
    logic signed [11:0] sh;
    logic signed [9:0] v;
    logic up;
    sh = g >>> 3;
    up = (g[2:0] > 3'd4) || ((g[2:0] == 3'd4) && sh[0]);
    v  = 10'(sh) + $signed({9'b0, up});
    priority if (v > 10'sd127) begin
      div8_even = 8'sd127;
    end else if (v < -10'sd128) begin
      div8_even = -8'sd128;
    end else begin
      div8_even = v[7:0];
    end
  endfunction

  // one square root step per cycle
  logic [15:0] sbit;
  logic [16:0] trial;
  logic signed [21:0] gx_w, gy_w;
  logic [21:0] sq_sum;
  assign sbit   = 16'(1) << {k_r, 1'b0};
  assign trial  = 17'(sres_r) + 17'(sbit);
  // squares are formed at full width so they cannot wrap
  assign gx_w   = 22'(gx_r);
  assign gy_w   = 22'(gy_r);
  assign sq_sum = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = flags_r.emit ? S_CALC : S_IDLE;
      S_CALC: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ROOT;
      S_ROOT: if (k_r == 3'd0) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = emi_last ? S_IDLE : S_CALC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fw_r    <= segm_pkg::FW_RESET;
      fh_r    <= segm_pkg::FH_RESET;
      col_r   <= '0;
      row_r   <= '0;
      flags_r <= '0;
      emi_r   <= '0;
      k_r     <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == segm_pkg::REG_WIDTH) begin
          fw_r <= pwdata[segm_pkg::FW_W-1:0];
        end else begin
          fh_r <= pwdata[FH_W-1:0];
        end
        col_r <= '0;
        row_r <= '0;
      end
      if (in_acc) begin
        flags_r.row_one  <= (row_r == FH_W'(1));
        flags_r.last_row <= (row_r == h_last);
        flags_r.col_one  <= (col_r == CW'(1));
        flags_r.col_last <= (col_r == w_last);
        flags_r.emit     <= (row_r != '0) && (col_r != '0);
      end
      if (state_r == S_READ) begin
        for (int i = 0; i < 6; i++) win_r[i] <= win_r[i + 3];
        win_r[6] <= flags_r.row_one ? pix_r : up_rd;
        win_r[7] <= lo_rd;
        win_r[8] <= pix_r;
        emi_r    <= '0;
        // counters move once the column has been written back
        if (flags_r.col_last) begin
          col_r <= '0;
          row_r <= (row_r == h_last) ? '0 : row_r + FH_W'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (state_r == S_SQ) k_r <= 3'd7;
      if (state_r == S_ROOT) k_r <= k_r - 3'd1;
      if (state_r == S_OUT && !out_stall) emi_r <= emi_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= in_pixel;
    if (state_r == S_CALC) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
      re_r <= is_edge;
      fe_r <= is_edge && fold;
    end
    if (state_r == S_SQ) begin
      sx_r   <= sq_sum[20:6];
      sres_r <= '0;
      gxo_r  <= div8_even(gx_r);
      gyo_r  <= div8_even(gy_r);
    end
    if (state_r == S_ROOT) begin
      if (17'(sx_r) >= trial) begin
        sx_r   <= 15'(17'(sx_r) - trial);
        sres_r <= (sres_r >> 1) + sbit;
      end else begin
        sres_r <= sres_r >> 1;
      end
    end
  end

  assign out_valid     = (state_r == S_OUT);
  assign out_grad_x    = gxo_r;
  assign out_grad_y    = gyo_r;
  assign out_magnitude = sres_r[7:0];
  assign out_row_end   = re_r;
  assign out_frame_end = fe_r;

  `SEGM_ASSERT_IMP(a_busy_while_shown, out_valid, in_stall)
  `SEGM_ASSERT_IMP(a_frame_end_on_row_end, out_valid && out_frame_end, out_row_end)
  `SEGM_ASSERT_NXT(a_accept_reads, in_acc, state_r == S_READ)
  `SEGM_ASSERT_NXT(a_root_done, state_r == S_ROOT && k_r == 3'd0, out_valid)
endmodule
